[hdl/tci_pkg.sv]
// Package for the thruster command interlock: request codes, payload structs,
// the front-to-back job record and the pulse arithmetic. No dependencies.
`timescale 1ns / 1ps
package tci_pkg;

	localparam logic [3:0] CHAN_BASE = 4'd10;
	localparam int PULSE_STEP_US = 5;
	localparam int QDEPTH = 2;

	typedef enum logic [3:0] {
		REQ_INIT = 4'd0, REQ_HORIZ_EN = 4'd1, REQ_SYNC_EN = 4'd2, REQ_VBASE = 4'd3,
		REQ_VSET = 4'd4, REQ_HBASE = 4'd5, REQ_HSET = 4'd6, REQ_STOPALL = 4'd7,
		REQ_MOVEALL = 4'd8, REQ_STOPV = 4'd9, REQ_MOVEV = 4'd10, REQ_STOPH = 4'd11,
		REQ_MOVEH = 4'd12, REQ_VAPPLY = 4'd13, REQ_GETBASE = 4'd14, REQ_GETREAL = 4'd15
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_BAD_ARG = 2'd1, ST_NOT_READY = 2'd2, ST_SAFETY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_CMD_MIN = 2'd0, CFG_CMD_MAX = 2'd1, CFG_NEUTRAL = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0]        req_type;
		logic [3:0]        channel;
		logic              enable;
		logic signed [7:0] command_a;
		logic signed [7:0] command_b;
		logic signed [7:0] command_c;
		logic signed [7:0] command_d;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              write_valid;
		logic [3:0]        out_channel;
		logic [11:0]       pwm_width;
		logic signed [7:0] read_value;
		logic              last;
	} out_item_t;

	// job: either one answer, or a run of writes
	typedef struct packed {
		logic              is_run;
		logic [1:0]        status;
		logic signed [7:0] read_value;
		logic [2:0]        idx0;
		logic [2:0]        count;
		logic signed [7:0] cmd0;
		logic signed [7:0] cmd1;
		logic signed [7:0] cmd2;
		logic signed [7:0] cmd3;
		logic signed [7:0] cmd4;
		logic signed [7:0] cmd5;
	} job_t;

	function automatic logic [11:0] pulse_of(logic [11:0] neutral, logic signed [7:0] cmd);
		logic signed [14:0] p;
		begin
			p = $signed({3'b000, neutral}) + 15'(PULSE_STEP_US) * 15'(cmd);
			if (p < 0)
				pulse_of = 12'd0;
			else if (p > 15'sd4095)
				pulse_of = 12'hFFF;
			else
				pulse_of = p[11:0];
		end
	endfunction

endpackage

[hdl/tci_front.sv]
// Front part: accepts requests, checks interlocks, updates state and emits
// one job per request into the queue. Depends on tci_pkg.
`timescale 1ns / 1ps
module tci_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  tci_pkg::in_item_t item,
	input  logic signed [7:0] cmd_min,
	input  logic [6:0]       cmd_max,
	output tci_pkg::job_t    job
);
	import tci_pkg::*;

	logic ready_q, all_q, vst_q, hst_q, vmode_q, hmode_q;
	logic signed [7:0] vbase_q, svbase_q, hbase_q;
	logic signed [7:0] vind_q [4];
	logic signed [7:0] hind_q [2];
	logic signed [7:0] app_q [6];

	logic ready_d, all_d, vst_d, hst_d, vmode_d, hmode_d;
	logic signed [7:0] vbase_d, svbase_d, hbase_d;
	logic signed [7:0] vind_d [4];
	logic signed [7:0] hind_d [2];
	logic signed [7:0] app_d [6];
	logic signed [7:0] cm [6];
	logic commit;

	function automatic logic vok(logic signed [7:0] c, logic signed [7:0] mn, logic [6:0] mx);
		vok = (c >= mn) && ($signed({c[7], c}) <= $signed({2'b00, mx}));
	endfunction

	always_comb begin
		logic vb, hb, ok;
		logic [3:0] rel;
		vb = all_q | vst_q;
		hb = all_q | hst_q;
		rel = item.channel - CHAN_BASE;
		ready_d = ready_q; all_d = all_q; vst_d = vst_q; hst_d = hst_q;
		vmode_d = vmode_q; hmode_d = hmode_q;
		vbase_d = vbase_q; svbase_d = svbase_q; hbase_d = hbase_q;
		vind_d = vind_q; hind_d = hind_q; app_d = app_q;
		for (int i = 0; i < 6; i++)
			cm[i] = 8'sd0;
		job = '0;
		job.status = ST_OK;
		commit = 1'b0;
		ok = 1'b1;
		unique case (req_t'(item.req_type))
			REQ_VSET:
				ok = item.channel >= CHAN_BASE && item.channel <= CHAN_BASE + 4'd3
					&& vok(item.command_a, cmd_min, cmd_max);
			REQ_HSET:
				ok = item.channel >= CHAN_BASE + 4'd4 && item.channel <= CHAN_BASE + 4'd5
					&& vok(item.command_a, cmd_min, cmd_max);
			REQ_VBASE, REQ_HBASE:
				ok = vok(item.command_a, cmd_min, cmd_max);
			REQ_GETBASE, REQ_GETREAL:
				ok = item.channel >= CHAN_BASE && item.channel <= CHAN_BASE + 4'd5;
			default: ok = 1'b1;
		endcase
		if (req_t'(item.req_type) == REQ_INIT) begin
			if (!vok(8'sd0, cmd_min, cmd_max)) begin
				job.status = ST_BAD_ARG;
				ready_d = 1'b0;
			end else begin
				ready_d = 1'b1; all_d = 1'b0; vst_d = 1'b0; hst_d = 1'b0;
				vmode_d = 1'b1; hmode_d = 1'b1;
				vbase_d = '0; svbase_d = '0; hbase_d = '0;
				for (int i = 0; i < 4; i++) vind_d[i] = '0;
				for (int i = 0; i < 2; i++) hind_d[i] = '0;
				job.is_run = 1'b1; job.count = 3'd6; job.idx0 = 3'd0;
				commit = 1'b1;
			end
		end else if (!ok) begin
			job.status = ST_BAD_ARG;
		end else if (!ready_q) begin
			job.status = ST_NOT_READY;
		end else begin
			unique case (req_t'(item.req_type))
				REQ_HORIZ_EN: begin
					if (item.enable != vmode_q) begin
						if (item.enable) begin
							vbase_d = svbase_q; vmode_d = 1'b1;
							if (!vb) begin
								for (int i = 0; i < 4; i++) cm[i] = svbase_q;
								job.is_run = 1'b1; job.count = 3'd4; commit = 1'b1;
							end
						end else begin
							svbase_d = vbase_q;
							if (!vb)
								for (int i = 0; i < 4; i++) vind_d[i] = app_q[i];
							vmode_d = 1'b0;
						end
					end
				end
				REQ_SYNC_EN: begin
					if (item.enable != hmode_q) begin
						hmode_d = item.enable;
						if (!hb) begin
							cm[0] = item.enable ? hbase_q : hind_q[0];
							cm[1] = item.enable ? hbase_q : hind_q[1];
							job.is_run = 1'b1; job.count = 3'd2; job.idx0 = 3'd4;
							commit = 1'b1;
						end
					end
				end
				REQ_VBASE: begin
					if (vb) job.status = ST_SAFETY;
					else begin
						for (int i = 0; i < 4; i++) cm[i] = item.command_a;
						if (vmode_q) vbase_d = item.command_a;
						else for (int i = 0; i < 4; i++) vind_d[i] = item.command_a;
						job.is_run = 1'b1; job.count = 3'd4; commit = 1'b1;
					end
				end
				REQ_VSET: begin
					if (vb || vmode_q) job.status = ST_SAFETY;
					else begin
						vind_d[rel[1:0]] = item.command_a;
						cm[0] = item.command_a;
						job.is_run = 1'b1; job.count = 3'd1; job.idx0 = rel[2:0];
						commit = 1'b1;
					end
				end
				REQ_HBASE: begin
					if (hb) job.status = ST_SAFETY;
					else begin
						cm[0] = item.command_a; cm[1] = item.command_a;
						if (hmode_q) hbase_d = item.command_a;
						else begin
							hind_d[0] = item.command_a; hind_d[1] = item.command_a;
						end
						job.is_run = 1'b1; job.count = 3'd2; job.idx0 = 3'd4;
						commit = 1'b1;
					end
				end
				REQ_HSET: begin
					if (hb || hmode_q) job.status = ST_SAFETY;
					else begin
						hind_d[rel[0]] = item.command_a;
						cm[0] = item.command_a;
						job.is_run = 1'b1; job.count = 3'd1; job.idx0 = rel[2:0];
						commit = 1'b1;
					end
				end
				REQ_STOPALL: begin
					all_d = 1'b1; job.is_run = 1'b1; job.count = 3'd6; commit = 1'b1;
				end
				REQ_MOVEALL: all_d = 1'b0;
				REQ_STOPV: begin
					vst_d = 1'b1; job.is_run = 1'b1; job.count = 3'd4; commit = 1'b1;
				end
				REQ_MOVEV: vst_d = 1'b0;
				REQ_STOPH: begin
					hst_d = 1'b1; job.is_run = 1'b1; job.count = 3'd2; job.idx0 = 3'd4;
					commit = 1'b1;
				end
				REQ_MOVEH: hst_d = 1'b0;
				REQ_VAPPLY: begin
					if (!vmode_q || vb) job.status = ST_SAFETY;
					else begin
						cm[0] = item.command_a; cm[1] = item.command_b;
						cm[2] = item.command_c; cm[3] = item.command_d;
						job.is_run = 1'b1; job.count = 3'd4; commit = 1'b1;
					end
				end
				REQ_GETBASE: begin
					if (rel <= 4'd3) begin
						if (!vmode_q) job.status = ST_SAFETY;
						else job.read_value = vbase_q;
					end else begin
						if (!hmode_q) job.status = ST_SAFETY;
						else job.read_value = hbase_q;
					end
				end
				REQ_GETREAL: job.read_value = app_q[rel[2:0]];
				default: ;
			endcase
		end
		if (commit) begin
			for (int i = 0; i < 6; i++)
				if (3'(i) < job.count && !vok(cm[i], cmd_min, cmd_max))
					commit = 1'b0;
			if (!commit) begin
				job = '0;
				job.status = ST_BAD_ARG;
				ready_d = ready_q; all_d = all_q; vst_d = vst_q; hst_d = hst_q;
				vmode_d = vmode_q; hmode_d = hmode_q;
				vbase_d = vbase_q; svbase_d = svbase_q; hbase_d = hbase_q;
				vind_d = vind_q; hind_d = hind_q;
			end else begin
				for (int i = 0; i < 6; i++)
					if (3'(i) < job.count)
						app_d[3'(job.idx0 + 3'(i))] = cm[i];
			end
		end
		job.cmd0 = cm[0]; job.cmd1 = cm[1]; job.cmd2 = cm[2];
		job.cmd3 = cm[3]; job.cmd4 = cm[4]; job.cmd5 = cm[5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0; all_q <= 1'b0; vst_q <= 1'b0; hst_q <= 1'b0;
			vmode_q <= 1'b0; hmode_q <= 1'b0;
			vbase_q <= '0; svbase_q <= '0; hbase_q <= '0;
			for (int i = 0; i < 4; i++) vind_q[i] <= '0;
			for (int i = 0; i < 2; i++) hind_q[i] <= '0;
			for (int i = 0; i < 6; i++) app_q[i] <= '0;
		end else if (take) begin
			ready_q <= ready_d; all_q <= all_d; vst_q <= vst_d; hst_q <= hst_d;
			vmode_q <= vmode_d; hmode_q <= hmode_d;
			vbase_q <= vbase_d; svbase_q <= svbase_d; hbase_q <= hbase_d;
			vind_q <= vind_d; hind_q <= hind_d; app_q <= app_d;
		end
	end
endmodule

[hdl/tci_back.sv]
// Back part: job queue and result sequencer; expands runs into pulse writes
// through an output register. Depends on tci_pkg.
`timescale 1ns / 1ps
module tci_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_job,
	input  tci_pkg::job_t     job,
	output logic              full,
	input  logic [11:0]       neutral,
	input  logic              pop,
	output logic              empty,
	output tci_pkg::out_item_t result
);
	import tci_pkg::*;

	job_t q_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [2:0] step_q;
	logic out_v_q;
	out_item_t out_q;
	logic head_v, advance, done, rd;
	job_t h;
	logic signed [7:0] c;

	assign full = (cnt_q == 2'(QDEPTH));
	assign head_v = (cnt_q != 2'd0);
	assign h = q_q[rp_q];
	assign advance = head_v && (!out_v_q || pop);
	assign done = !h.is_run || (step_q + 3'd1 == h.count);
	assign rd = advance && done;
	assign empty = !out_v_q;
	assign result = out_q;

	always_comb begin
		unique case (step_q)
			3'd0: c = h.cmd0;
			3'd1: c = h.cmd1;
			3'd2: c = h.cmd2;
			3'd3: c = h.cmd3;
			3'd4: c = h.cmd4;
			default: c = h.cmd5;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_job)
			q_q[wp_q] <= job;
		if (advance) begin
			out_q.status <= h.status;
			out_q.write_valid <= h.is_run;
			out_q.out_channel <= h.is_run ? CHAN_BASE + 4'(h.idx0) + 4'(step_q) : 4'd0;
			out_q.pwm_width <= h.is_run ? pulse_of(neutral, c) : 12'd0;
			out_q.read_value <= h.is_run ? 8'sd0 : h.read_value;
			out_q.last <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; step_q <= '0; out_v_q <= 1'b0;
		end else begin
			if (push_job) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(push_job) - 2'(rd);
			if (advance) step_q <= done ? 3'd0 : step_q + 3'd1;
			if (advance) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("queue count overflow");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		head_v && h.is_run |-> step_q < h.count)
		else $error("step beyond run");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !pop |=> $stable(out_q))
		else $error("result changed while held");
`endif
endmodule

[hdl/thruster_command_interlock_unit.sv]
// Top level of the thruster command interlock: configuration registers,
// front checker and back sequencer. Depends on tci_pkg, tci_front, tci_back.
// A request is taken when the two-entry job queue has room; it yields one
// result, or one pulse write per channel (up to six), one per cycle from the
// back sequencer while its output is free or popped; requests queue behind a run.
`timescale 1ns / 1ps
module thruster_command_interlock_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tci_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output tci_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data
);
	import tci_pkg::*;

	logic signed [7:0] cmd_min_q;
	logic [6:0] cmd_max_q;
	logic [11:0] neutral_q;
	logic take;
	job_t job;

	assign cfg_ready = 1'b1;
	assign take = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_min_q <= -8'sd100; cmd_max_q <= 7'd100; neutral_q <= 12'd1500;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CMD_MIN: cmd_min_q <= cfg_data[7:0];
				CFG_CMD_MAX: cmd_max_q <= cfg_data[6:0];
				CFG_NEUTRAL: neutral_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tci_front u_front (.clk, .arst_n, .take, .item(in_item),
		.cmd_min(cmd_min_q), .cmd_max(cmd_max_q), .job);

	tci_back u_back (.clk, .arst_n, .push_job(take), .job, .full,
		.neutral(neutral_q), .pop, .empty, .result(out_item));
endmodule
